@@ rtl/flight_event_detector_unit_defines.svh @@
// Assertion macros used by the checker file of the flight event detector.
// No dependencies; include by bare file name.
`ifndef FLIGHT_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define FLIGHT_EVENT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FED_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fed_pkg.sv @@
// Package of the flight event detector: sizes, codes and the structs that
// pass between its modules. No dependencies.
`default_nettype none

package fed_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SUM_W        = 16 + $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W        = SUM_W + 2;

  // Input item kinds, carried on tuser.
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Bits of the trigger enable register.
  localparam int EN_BURN_ACCEL   = 0;
  localparam int EN_BURN_TIMEOUT = 1;
  localparam int EN_APO_VEL      = 2;
  localparam int EN_APO_TIMEOUT  = 3;

  typedef enum logic [2:0] {
    REG_IGN_TRIGGER   = 3'd0,
    REG_IGN_MARGIN    = 3'd1,
    REG_GRACE_PERIOD  = 3'd2,
    REG_BURN_MARGIN   = 3'd3,
    REG_BURN_TIMEOUT  = 3'd4,
    REG_APO_MARGIN    = 3'd5,
    REG_APO_TIMEOUT   = 3'd6,
    REG_TRIG_ENABLES  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] ignition_trigger;
    logic [14:0]        ignition_margin;
    logic [31:0]        grace_period;
    logic [14:0]        burnout_accel_margin;
    logic [31:0]        burnout_timeout;
    logic [14:0]        apogee_velocity_margin;
    logic [31:0]        apogee_timeout;
    logic [3:0]         trigger_enables;
  } fed_cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] accel_sum;
    logic signed [SUM_W-1:0] velocity_sum;
    logic                    full;
  } fed_win_t;

  typedef struct packed {
    logic        ignited;
    logic        burned_out;
    logic        apogee_reached;
    logic [31:0] ignition_time;
    logic [31:0] burnout_time;
    logic [31:0] apogee_time;
  } fed_res_t;

endpackage

`default_nettype wire

@@ rtl/fed_cell.sv @@
// One slot of the moving-average window: holds an accel and a velocity sample
// and hands them to the next slot on every push. No dependencies.
`default_nettype none

module fed_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic signed [15:0] accel_in,
  input  wire logic signed [15:0] velocity_in,
  output logic signed [15:0]      accel,
  output logic signed [15:0]      velocity
);

  // Window contents reset to zero so the sums stay exact before fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel    <= '0;
      velocity <= '0;
    end else if (shift) begin
      accel    <= accel_in;
      velocity <= velocity_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fed_window.sv @@
// Moving-average window: a chain of fed_cell slots, the running sums and the
// fill count. Depends on fed_pkg and fed_cell.
`default_nettype none

module fed_window (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic signed [15:0] accel_in,
  input  wire logic signed [15:0] velocity_in,
  output fed_pkg::fed_win_t       win
);
  import fed_pkg::*;

  logic signed [15:0]       a_chain [0:WINDOW_DEPTH];
  logic signed [15:0]       v_chain [0:WINDOW_DEPTH];
  logic signed [SUM_W-1:0]  accel_sum;
  logic signed [SUM_W-1:0]  velocity_sum;
  logic [FILL_W-1:0]        fill;

  assign a_chain[0] = accel_in;
  assign v_chain[0] = velocity_in;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    fed_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (push),
      .accel_in    (a_chain[i]),
      .velocity_in (v_chain[i]),
      .accel       (a_chain[i+1]),
      .velocity    (v_chain[i+1])
    );
  end

  // The last slot holds the sample that leaves the window on this push.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_sum    <= '0;
      velocity_sum <= '0;
      fill         <= '0;
    end else if (push) begin
      accel_sum    <= accel_sum + SUM_W'(accel_in) - SUM_W'(a_chain[WINDOW_DEPTH]);
      velocity_sum <= velocity_sum + SUM_W'(velocity_in) - SUM_W'(v_chain[WINDOW_DEPTH]);
      if (fill != FILL_W'(WINDOW_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  assign win.accel_sum    = accel_sum;
  assign win.velocity_sum = velocity_sum;
  assign win.full         = (fill == FILL_W'(WINDOW_DEPTH));

endmodule

`default_nettype wire

@@ rtl/fed_events.sv @@
// Event logic of the flight event detector: epoch, sticky event flags and
// times, which also form the output register. Depends on fed_pkg.
`default_nettype none

module fed_events (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        commit,
  input  wire logic        action,
  input  wire logic [31:0] time_ms,
  input  wire fed_pkg::fed_win_t win,
  input  wire fed_pkg::fed_cfg_t cfg,
  output fed_pkg::fed_res_t res
);
  import fed_pkg::*;

  logic [31:0]             epoch_time;
  fed_res_t                res_next;
  logic [31:0]             since_epoch;
  logic [31:0]             flight;
  logic [31:0]             ign_ref;
  logic signed [CMP_W-1:0] ign_margin_d;
  logic signed [CMP_W-1:0] ign_lhs;
  logic signed [CMP_W-1:0] trig_d;
  logic signed [CMP_W-1:0] burn_margin_d;
  logic signed [CMP_W-1:0] apo_margin_d;
  logic                    fire_ign;
  logic                    ign_now;
  logic                    fire_burn;
  logic                    fire_apo;

  always_comb begin
    ign_margin_d  = CMP_W'(cfg.ignition_margin) * CMP_W'(WINDOW_DEPTH);
    burn_margin_d = CMP_W'(cfg.burnout_accel_margin) * CMP_W'(WINDOW_DEPTH);
    apo_margin_d  = CMP_W'(cfg.apogee_velocity_margin) * CMP_W'(WINDOW_DEPTH);
    trig_d        = CMP_W'(cfg.ignition_trigger) * CMP_W'(WINDOW_DEPTH);
    ign_lhs       = CMP_W'(win.accel_sum) + ign_margin_d;
    since_epoch   = time_ms - epoch_time;

    fire_ign = !res.ignited && (since_epoch >= cfg.grace_period) && win.full &&
               (ign_lhs > trig_d);
    ign_now  = res.ignited || fire_ign;
    // Ignition on this very item gives a flight time of zero.
    ign_ref  = res.ignited ? res.ignition_time : time_ms;
    flight   = time_ms - ign_ref;

    fire_burn = ign_now && !res.burned_out &&
                ((cfg.trigger_enables[EN_BURN_ACCEL] && win.full &&
                  (CMP_W'(win.accel_sum) < burn_margin_d)) ||
                 (cfg.trigger_enables[EN_BURN_TIMEOUT] &&
                  (flight >= cfg.burnout_timeout)));
    fire_apo  = ign_now && !res.apogee_reached &&
                ((cfg.trigger_enables[EN_APO_VEL] && win.full &&
                  (CMP_W'(win.velocity_sum) < apo_margin_d)) ||
                 (cfg.trigger_enables[EN_APO_TIMEOUT] &&
                  (flight >= cfg.apogee_timeout)));

    res_next = res;
    if (action == ACT_RESTART) begin
      res_next = '0;
    end else begin
      if (fire_ign) begin
        res_next.ignited       = 1'b1;
        res_next.ignition_time = time_ms;
      end
      if (fire_burn) begin
        res_next.burned_out   = 1'b1;
        res_next.burnout_time = time_ms;
      end
      if (fire_apo) begin
        res_next.apogee_reached = 1'b1;
        res_next.apogee_time    = time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res        <= '0;
      epoch_time <= '0;
    end else if (commit) begin
      res <= res_next;
      if (action == ACT_RESTART) begin
        epoch_time <= time_ms;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/flight_event_detector_unit.sv @@
// Flight event detector, top level.
// Path: an accepted input transaction waits in stage A, and its result is
// registered in the event state when stage A moves on.
// Throughput: one transaction per cycle while results are taken; the window
// sums update at accept, the event state (also the output register) as stage A moves.
// Reset (rst, synchronous, active high) clears registers, window and events.
`default_nettype none

module flight_event_detector_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // time_ms[31:0], vertical_accel[47:32],
                                       // vertical_velocity[63:48]
  input  wire logic         s_tuser,   // action: 0 sample, 1 restart
  // Result stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // ignited[0], burned_out[1],
                                       // apogee_reached[2], ignition_time[34:3],
                                       // burnout_time[66:35], apogee_time[98:67],
                                       // zero fill[103:99]
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import fed_pkg::*;

  fed_cfg_t    cfg;
  fed_win_t    win;
  fed_res_t    res;
  reg_idx_t    reg_idx;
  logic        cfg_write;

  // Stage A holds an accepted transaction while the window sums for it settle.
  logic        a_valid;
  logic        a_action;
  logic [31:0] a_time;
  logic        a_move;
  logic        accept;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes in
  // its access cycle. The register index is the word address.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IGN_TRIGGER:  cfg.ignition_trigger       <= pwdata[15:0];
        REG_IGN_MARGIN:   cfg.ignition_margin        <= pwdata[14:0];
        REG_GRACE_PERIOD: cfg.grace_period           <= pwdata;
        REG_BURN_MARGIN:  cfg.burnout_accel_margin   <= pwdata[14:0];
        REG_BURN_TIMEOUT: cfg.burnout_timeout        <= pwdata;
        REG_APO_MARGIN:   cfg.apogee_velocity_margin <= pwdata[14:0];
        REG_APO_TIMEOUT:  cfg.apogee_timeout         <= pwdata;
        REG_TRIG_ENABLES: cfg.trigger_enables        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value; the trigger reads back sign-extended.
  always_comb begin
    case (reg_idx)
      REG_IGN_TRIGGER:  prdata = 32'(cfg.ignition_trigger);
      REG_IGN_MARGIN:   prdata = 32'(cfg.ignition_margin);
      REG_GRACE_PERIOD: prdata = cfg.grace_period;
      REG_BURN_MARGIN:  prdata = 32'(cfg.burnout_accel_margin);
      REG_BURN_TIMEOUT: prdata = cfg.burnout_timeout;
      REG_APO_MARGIN:   prdata = 32'(cfg.apogee_velocity_margin);
      REG_APO_TIMEOUT:  prdata = cfg.apogee_timeout;
      REG_TRIG_ENABLES: prdata = 32'(cfg.trigger_enables);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. Stage A moves into the output register whenever that register
  // is empty or its transaction is being taken, and a new input transaction is
  // taken whenever stage A is empty or moving on. Back-to-back transactions
  // flow at one per cycle; a waiting result holds up the input only once
  // stage A is also occupied.
  // ---------------------------------------------------------------------------
  assign a_move   = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || a_move;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_action <= s_tuser;
      a_time   <= s_tdata[31:0];
    end
  end

  // The window sums change only on an accepted sample, at the same edge that
  // loads stage A, so they always belong to the transaction in stage A.
  // A restart leaves the window untouched.
  fed_window u_window (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && (s_tuser == ACT_SAMPLE)),
    .accel_in    (s_tdata[47:32]),
    .velocity_in (s_tdata[63:48]),
    .win         (win)
  );

  // Event state updates when stage A moves on; it is also the result shown.
  fed_events u_events (
    .clk     (clk),
    .rst     (rst),
    .commit  (a_move),
    .action  (a_action),
    .time_ms (a_time),
    .win     (win),
    .cfg     (cfg),
    .res     (res)
  );

  assign m_tdata = {5'b0, res.apogee_time, res.burnout_time, res.ignition_time,
                    res.apogee_reached, res.burned_out, res.ignited};

endmodule

`default_nettype wire

@@ rtl/fed_checker.sv @@
// Port-level checker for the flight event detector and its bind statement.
// Depends on flight_event_detector_unit_defines.svh.
`default_nettype none
`include "flight_event_detector_unit_defines.svh"

module fed_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [103:0] m_tdata
);

  // A stalled result transaction stays and keeps its data.
  `FED_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Burnout and apogee are only ever reported after ignition.
  `FED_ASSERT_IMPL(a_burn_after_ign, clk, rst, m_tvalid && m_tdata[1], m_tdata[0], "burnout without ignition")
  `FED_ASSERT_IMPL(a_apo_after_ign, clk, rst, m_tvalid && m_tdata[2], m_tdata[0], "apogee without ignition")

  // Leaving reset, the block is empty and ready for an input transaction.
  `FED_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), s_tready && !m_tvalid, "not empty after reset")

endmodule

bind flight_event_detector_unit fed_checker u_fed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
